[hdl/buffer_pool_clock_replacement_defines.svh]
// ----------------------------------------------------------------------------
// Buffer pool clock replacement: assertion macros
// Shared property shorthands for the frame table checks.
// ----------------------------------------------------------------------------
`ifndef BUFFER_POOL_CLOCK_REPLACEMENT_DEFINES_SVH
`define BUFFER_POOL_CLOCK_REPLACEMENT_DEFINES_SVH

// same-cycle implication
`define BPCR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpcr: implication check failed");

// next-cycle implication
`define BPCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpcr: next-cycle check failed");

`endif

[hdl/bpcr_pkg.sv]
// ----------------------------------------------------------------------------
// bpcr_pkg
// Types, codes and field widths of the clock replacement frame table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpcr_pkg;

   localparam int NUM_FRAMES_DEF = 16;
   localparam int PAGE_BITS_DEF  = 16;

   localparam int OP_W       = 2;
   localparam int PAGE_W     = 16;
   localparam int IDX_W      = 4;
   localparam int STATUS_W   = 3;
   localparam int PIN_W      = 8;
   localparam int CFG_W      = 5;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_USED_W = IDX_W + STATUS_W + PIN_W;
   localparam int RSP_DATA_W = 16;

   localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FILLED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REPLACED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ALL_PINNED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd4;

   localparam logic [PIN_W-1:0] PIN_MAX   = 8'hFF;
   localparam logic [PIN_W-1:0] PIN_FIRST = 8'd1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SWEEP,
      S_RESULT
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_FAIL,
      ACT_HIT,
      ACT_FILL,
      ACT_SWEEP_START,
      ACT_SWEEP_STEP
   } act_type;

   typedef struct packed {
      act_type act;
      logic    start;
      logic    scan_en;
      logic    out_load;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic is_request;
      logic scan_done;
      logic hit;
      logic empty_found;
      logic sweep_take;
      logic sweep_last;
      logic out_free;
   } sts_type;

endpackage

[hdl/bpcr_ram.sv]
// ----------------------------------------------------------------------------
// bpcr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bpcr_datapath.sv]
// ----------------------------------------------------------------------------
// bpcr_datapath
// Frame table storage, lookup scan, clock hand sweep and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpcr_datapath import bpcr_pkg::*; #(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   input  logic                  csr_valid,
   input  logic [CFG_W-1:0]      csr_data,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int FW        = $clog2(NUM_FRAMES);
   localparam int CW        = $clog2(NUM_FRAMES + 1);
   localparam int PW        = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
   localparam int RW        = PW + PIN_W;
   localparam int CFG_RESET = (NUM_FRAMES > 16) ? 16 : NUM_FRAMES;

   logic [CFG_W-1:0]      cfg_ff, cfg_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [PW-1:0]         page_ff, page_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [FW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  hit_ff, hit_in;
   logic [FW-1:0]         hit_idx_ff, hit_idx_in;
   logic [PIN_W-1:0]      hit_pin_ff, hit_pin_in;
   logic                  empty_ff, empty_in;
   logic [FW-1:0]         empty_idx_ff, empty_idx_in;
   logic [FW-1:0]         hand_ff, hand_in;
   logic [CW:0]           sweep_cnt_ff, sweep_cnt_in;
   logic [NUM_FRAMES-1:0] valid_ff, valid_in;
   logic [NUM_FRAMES-1:0] pinned_ff, pinned_in;
   logic [NUM_FRAMES-1:0] ref_ff, ref_in;
   logic [IDX_W-1:0]      res_idx_ff, res_idx_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [PIN_W-1:0]      res_pin_ff, res_pin_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CW-1:0]    n_active;
   logic             issue;
   logic [RW-1:0]    ram_rdata;
   logic [PW-1:0]    rd_page;
   logic [PIN_W-1:0] rd_pin;
   logic             cmp_hit;
   logic             cmp_empty;
   logic [PIN_W-1:0] pin_inc;
   logic             take;
   logic             last;
   logic [FW-1:0]    hand_next;
   logic             ram_we;
   logic [FW-1:0]    ram_waddr;
   logic [RW-1:0]    ram_wdata;

   always_comb begin
      if (cfg_ff == '0) begin
         n_active = CW'(1);
      end else if (32'(cfg_ff) > NUM_FRAMES) begin
         n_active = CW'(NUM_FRAMES);
      end else begin
         n_active = CW'(cfg_ff);
      end
   end

   assign issue     = cmd.scan_en && !hit_ff && (scan_ff != n_active);
   assign rd_page   = ram_rdata[PW-1:0];
   assign rd_pin    = ram_rdata[RW-1:PW];
   assign cmp_hit   = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_page == page_ff) && !hit_ff;
   assign cmp_empty = cmp_vld_ff && !valid_ff[cmp_idx_ff] && !empty_ff;
   assign pin_inc   = (hit_pin_ff == PIN_MAX) ? hit_pin_ff : hit_pin_ff + 1'b1;
   assign take      = !ref_ff[hand_ff] && !pinned_ff[hand_ff];
   assign last      = (sweep_cnt_ff == ({n_active, 1'b0} - 1'b1));
   assign hand_next = ((CW'(hand_ff) + 1'b1) == n_active) ? '0 : hand_ff + 1'b1;

   always_comb begin
      cfg_in        = csr_valid ? csr_data : cfg_ff;
      op_in         = op_ff;
      page_in       = page_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = issue;
      cmp_idx_in    = scan_ff[FW-1:0];
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_pin_in    = hit_pin_ff;
      empty_in      = empty_ff;
      empty_idx_in  = empty_idx_ff;
      hand_in       = hand_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      valid_in      = valid_ff;
      pinned_in     = pinned_ff;
      ref_in        = ref_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      res_pin_in    = res_pin_ff;
      ram_we        = 1'b0;
      ram_waddr     = hit_idx_ff;
      ram_wdata     = {pin_inc, page_ff};

      if (cmd.start) begin
         op_in      = req_tuser;
         page_in    = req_tdata[PW-1:0];
         scan_in    = '0;
         cmp_vld_in = 1'b0;
         hit_in     = 1'b0;
         empty_in   = 1'b0;
      end

      if (issue) begin
         scan_in = scan_ff + 1'b1;
      end
      if (cmp_hit) begin
         hit_in     = 1'b1;
         hit_idx_in = cmp_idx_ff;
         hit_pin_in = rd_pin;
      end
      if (cmp_empty) begin
         empty_in     = 1'b1;
         empty_idx_in = cmp_idx_ff;
      end

      case (cmd.act)
         ACT_FAIL: begin
            res_idx_in    = '0;
            res_status_in = ST_INVALID;
            res_pin_in    = '0;
         end
         ACT_HIT: begin
            res_idx_in    = IDX_W'(hit_idx_ff);
            res_status_in = ST_HIT;
            res_pin_in    = hit_pin_ff;
            case (op_ff)
               OP_REQUEST: begin
                  ram_we                = 1'b1;
                  pinned_in[hit_idx_ff] = 1'b1;
                  ref_in[hit_idx_ff]    = 1'b1;
                  res_pin_in            = pin_inc;
               end
               OP_RELEASE: begin
                  pinned_in[hit_idx_ff] = 1'b0;
               end
               default: begin
               end
            endcase
         end
         ACT_FILL: begin
            ram_we                  = 1'b1;
            ram_waddr               = empty_idx_ff;
            ram_wdata               = {PIN_FIRST, page_ff};
            valid_in[empty_idx_ff]  = 1'b1;
            pinned_in[empty_idx_ff] = 1'b1;
            ref_in[empty_idx_ff]    = 1'b1;
            res_idx_in              = IDX_W'(empty_idx_ff);
            res_status_in           = ST_FILLED;
            res_pin_in              = PIN_FIRST;
         end
         ACT_SWEEP_START: begin
            hand_in      = (CW'(hand_ff) >= n_active) ? '0 : hand_ff;
            sweep_cnt_in = '0;
         end
         ACT_SWEEP_STEP: begin
            hand_in = hand_next;
            if (take) begin
               ram_we             = 1'b1;
               ram_waddr          = hand_ff;
               ram_wdata          = {PIN_FIRST, page_ff};
               valid_in[hand_ff]  = 1'b1;
               pinned_in[hand_ff] = 1'b1;
               ref_in[hand_ff]    = 1'b1;
               res_idx_in         = IDX_W'(hand_ff);
               res_status_in      = ST_REPLACED;
               res_pin_in         = PIN_FIRST;
            end else begin
               ref_in[hand_ff] = 1'b0;
               sweep_cnt_in    = sweep_cnt_ff + 1'b1;
               if (last) begin
                  res_idx_in    = '0;
                  res_status_in = ST_ALL_PINNED;
                  res_pin_in    = '0;
               end
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                         res_pin_ff, res_status_ff, res_idx_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_W'(CFG_RESET);
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         empty_ff     <= 1'b0;
         hand_ff      <= '0;
         valid_ff     <= '0;
         pinned_ff    <= '0;
         ref_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         cmp_vld_ff   <= cmp_vld_in;
         hit_ff       <= hit_in;
         empty_ff     <= empty_in;
         hand_ff      <= hand_in;
         valid_ff     <= valid_in;
         pinned_ff    <= pinned_in;
         ref_ff       <= ref_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      page_ff       <= page_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_pin_ff    <= hit_pin_in;
      empty_idx_ff  <= empty_idx_in;
      sweep_cnt_ff  <= sweep_cnt_in;
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
      res_pin_ff    <= res_pin_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // page number and pin count of each frame
   bpcr_ram #(
      .WIDTH (RW),
      .DEPTH (NUM_FRAMES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (issue),
      .rd_addr (scan_ff[FW-1:0]),
      .rd_data (ram_rdata)
   );

   assign sts.bad         = (page_ff == '0) ||
                            !((op_ff == OP_REQUEST) || (op_ff == OP_WRITE) ||
                              (op_ff == OP_RELEASE));
   assign sts.is_request  = (op_ff == OP_REQUEST);
   assign sts.scan_done   = !cmp_vld_ff && (hit_ff || (scan_ff == n_active));
   assign sts.hit         = hit_ff;
   assign sts.empty_found = empty_ff;
   assign sts.sweep_take  = take;
   assign sts.sweep_last  = last;
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hdl/bpcr_ctrl.sv]
// ----------------------------------------------------------------------------
// bpcr_ctrl
// Sequencer: accept, lookup scan, clock sweep, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpcr_ctrl import bpcr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.bad) begin
               state_in = S_RESULT;
            end else if (sts.scan_done) begin
               if (sts.hit || !sts.is_request || sts.empty_found) begin
                  state_in = S_RESULT;
               end else begin
                  state_in = S_SWEEP;
               end
            end
         end
         S_SWEEP: begin
            if (sts.sweep_take || sts.sweep_last) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.act      = ACT_NONE;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         S_SCAN: begin
            if (sts.bad) begin
               cmd.act = ACT_FAIL;
            end else begin
               cmd.scan_en = 1'b1;
               if (sts.scan_done) begin
                  if (sts.hit) begin
                     cmd.act = ACT_HIT;
                  end else if (!sts.is_request) begin
                     cmd.act = ACT_FAIL;
                  end else if (sts.empty_found) begin
                     cmd.act = ACT_FILL;
                  end else begin
                     cmd.act = ACT_SWEEP_START;
                  end
               end
            end
         end
         S_SWEEP: begin
            cmd.act = ACT_SWEEP_STEP;
         end
         S_RESULT: begin
            cmd.out_load = sts.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/buffer_pool_clock_replacement.sv]
// ----------------------------------------------------------------------------
// buffer_pool_clock_replacement
// Page buffer pool frame table with clock (second chance) replacement.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  req      in         tdata: page_number; tuser: operation
//  rsp      out        tdata: frame_index, status, pin_count_now
//  csr      in         data: frames_in_use
//
//  A beat passes through accept, a lookup scan (one frame per cycle through
//  the single read port of the frame RAM, stopping at a hit), on a
//  replacement a clock sweep of at most two passes of the hand over the
//  active frames, and result hand-off; n is the active frame count.
//  Reset is synchronous, clears all frames and the hand, and sets the frame
//  count to its default.
//  A waiting result beat does not hold off the next request beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "buffer_pool_clock_replacement_defines.svh"

module buffer_pool_clock_replacement import bpcr_pkg::*; #(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] page_number
   input  logic [OP_W-1:0]       req_tuser,   // [1:0] operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] frame_index, [6:4] status,
                                              // [14:7] pin_count_now, [15] zero
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_W-1:0]      csr_data
);

   cmd_type             cmd;
   sts_type             sts;
   logic [IDX_W-1:0]    rsp_idx;
   logic [STATUS_W-1:0] rsp_status;
   logic [PIN_W-1:0]    rsp_pin;

   assign csr_ready = 1'b1;

   bpcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bpcr_datapath #(
      .NUM_FRAMES (NUM_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign rsp_idx    = rsp_tdata[IDX_W-1:0];
   assign rsp_status = rsp_tdata[IDX_W +: STATUS_W];
   assign rsp_pin    = rsp_tdata[IDX_W + STATUS_W +: PIN_W];

   `BPCR_ASSERT_IMPLY(a_fail_zero, clock, reset,
      rsp_tvalid && (rsp_status == ST_INVALID || rsp_status == ST_ALL_PINNED),
      rsp_idx == '0 && rsp_pin == '0)
   `BPCR_ASSERT_IMPLY(a_claim_one_pin, clock, reset,
      rsp_tvalid && (rsp_status == ST_FILLED || rsp_status == ST_REPLACED),
      rsp_pin == PIN_FIRST)
   `BPCR_ASSERT_IMPLY(a_busy_no_accept, clock, reset,
      cmd.act != ACT_NONE, !req_tready)
   `BPCR_ASSERT_NEXT(a_load_shows, clock, reset,
      cmd.out_load, rsp_tvalid)

endmodule
